@@ design/hcbd_pkg.sv @@
package hcbd_pkg;

  // Size line length limit and chunk size accumulator width
  localparam int unsigned LINE_LIMIT = 19;
  localparam int unsigned SIZE_BITS  = 32;
  localparam int unsigned LINE_CNT_W = $clog2(LINE_LIMIT + 1);
  localparam int unsigned BODY_LEN_W = 32;

  localparam logic [7:0] CHAR_CR = 8'h0D;

  typedef enum logic [2:0] {
    PH_LINE  = 3'd0,
    PH_LF    = 3'd1,
    PH_DATA  = 3'd2,
    PH_TRAIL = 3'd3,
    PH_DONE  = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KIND_FRAME   = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_END     = 2'd2,
    KIND_IGNORED = 2'd3
  } kind_e;

  // Decoder state carried from one byte to the next
  typedef struct packed {
    phase_e                  phase;
    logic [SIZE_BITS-1:0]    size_accum;
    logic                    hex_stopped;
    logic [LINE_CNT_W-1:0]   line_chars;
    logic [SIZE_BITS-1:0]    bytes_left;
    logic                    trailer_skip;
    logic [BODY_LEN_W-1:0]   delivered;
  } dec_state_t;

  localparam dec_state_t STATE_RESET = '{
    phase:        PH_LINE,
    size_accum:   '0,
    hex_stopped:  1'b0,
    line_chars:   '0,
    bytes_left:   '0,
    trailer_skip: 1'b0,
    delivered:    '0
  };

  typedef struct packed {
    kind_e                 kind;
    logic [7:0]            payload_byte;
    logic [BODY_LEN_W-1:0] body_length;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_digit_t;

  // ASCII hex digit decode, either case
  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h37);
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

@@ design/hcbd_in_if.sv @@
interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_of_body;

  modport source (output valid, output in_byte, output start_of_body, input ready);
  modport sink   (input valid, input in_byte, input start_of_body, output ready);
endinterface

@@ design/hcbd_out_if.sv @@
interface hcbd_out_if;
  logic                           valid;
  logic                           ready;
  hcbd_pkg::kind_e                kind;
  logic [7:0]                     payload_byte;
  logic [hcbd_pkg::BODY_LEN_W-1:0] body_length;

  modport source (output valid, output kind, output payload_byte, output body_length,
                  input ready);
  modport sink   (input valid, input kind, input payload_byte, input body_length,
                  output ready);
endinterface

@@ design/hcbd_core.sv @@
// Next-state and result logic for one body byte
module hcbd_core (
  input  hcbd_pkg::dec_state_t state_i,
  input  logic [7:0]           byte_i,
  input  logic                 start_i,
  output hcbd_pkg::dec_state_t state_o,
  output hcbd_pkg::result_t    result_o
);

  hcbd_pkg::dec_state_t cur;
  hcbd_pkg::dec_state_t nxt;
  hcbd_pkg::hex_digit_t hex;
  hcbd_pkg::kind_e      kind;
  logic [7:0]           pay;
  logic [hcbd_pkg::SIZE_BITS-1:0] left_dec;

  always_comb begin
    // Start of body restarts at a size line with a zero count
    cur      = start_i ? hcbd_pkg::STATE_RESET : state_i;
    nxt      = cur;
    hex      = hcbd_pkg::hex_decode(byte_i);
    kind     = hcbd_pkg::KIND_FRAME;
    pay      = 8'd0;
    left_dec = cur.bytes_left - 1'b1;

    unique case (cur.phase)
      hcbd_pkg::PH_LINE: begin
        if (byte_i != hcbd_pkg::CHAR_CR &&
            cur.line_chars < hcbd_pkg::LINE_CNT_W'(hcbd_pkg::LINE_LIMIT)) begin
          nxt.line_chars = cur.line_chars + 1'b1;
          if (!cur.hex_stopped) begin
            if (hex.valid) begin
              nxt.size_accum = {cur.size_accum[hcbd_pkg::SIZE_BITS-5:0], hex.value};
            end else begin
              nxt.hex_stopped = 1'b1;
            end
          end
        end else begin
          nxt.phase = hcbd_pkg::PH_LF;
        end
      end
      hcbd_pkg::PH_LF: begin
        // Line feed byte is not checked
        if (cur.size_accum == '0) begin
          nxt.phase = hcbd_pkg::PH_DONE;
          kind      = hcbd_pkg::KIND_END;
        end else begin
          nxt.bytes_left = cur.size_accum;
          nxt.phase      = hcbd_pkg::PH_DATA;
        end
      end
      hcbd_pkg::PH_DATA: begin
        kind           = hcbd_pkg::KIND_PAYLOAD;
        pay            = byte_i;
        nxt.delivered  = cur.delivered + 1'b1;
        nxt.bytes_left = left_dec;
        if (left_dec == '0) begin
          nxt.phase        = hcbd_pkg::PH_TRAIL;
          nxt.trailer_skip = 1'b0;
        end
      end
      hcbd_pkg::PH_TRAIL: begin
        // Two bytes after the chunk, skipped unchecked
        if (cur.trailer_skip) begin
          nxt.trailer_skip = 1'b0;
          nxt.phase        = hcbd_pkg::PH_LINE;
          nxt.size_accum   = '0;
          nxt.hex_stopped  = 1'b0;
          nxt.line_chars   = '0;
        end else begin
          nxt.trailer_skip = 1'b1;
        end
      end
      default: begin
        kind = hcbd_pkg::KIND_IGNORED;
      end
    endcase

    state_o               = nxt;
    result_o.kind         = kind;
    result_o.payload_byte = pay;
    result_o.body_length  = nxt.delivered;
  end

endmodule

@@ design/http_chunked_body_decoder.sv @@
// Chunked transfer body decoder.
// body_i takes one raw body byte per request, with start_of_body set on the
// first byte of a new body. res_o returns exactly one result per byte: a
// framing byte, a payload byte, the end of the body (zero size chunk), or a
// byte ignored after the end, together with the running payload count.
// A byte accepted in one cycle shows its result in the next. Throughput is one
// byte per cycle while the receiver keeps up; the decode is a single pass of
// small logic between the state register and the result register.
// The result register acts as the output stage: body_i stays ready while it
// is empty or being taken in the same cycle, so a stalled receiver holds the
// result and stops input only for as long as it stalls.
// Reset clears the decoder to the start of a size line with a zero payload
// count and empties the result register.
module http_chunked_body_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  hcbd_in_if.sink    body_i,
  hcbd_out_if.source res_o
);

  hcbd_pkg::dec_state_t state_q;
  hcbd_pkg::dec_state_t state_d;
  hcbd_pkg::result_t    res_d;
  hcbd_pkg::result_t    res_q;
  logic                 res_valid_q;
  logic                 accept;

  assign body_i.ready = !res_valid_q || res_o.ready;
  assign accept       = body_i.valid && body_i.ready;

  hcbd_core u_core (
    .state_i  (state_q),
    .byte_i   (body_i.in_byte),
    .start_i  (body_i.start_of_body),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Decoder state, advanced once per accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hcbd_pkg::STATE_RESET;
      res_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q     <= state_d;
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.kind         = res_q.kind;
  assign res_o.payload_byte = res_q.payload_byte;
  assign res_o.body_length  = res_q.body_length;

endmodule

@@ design/hcbd_checker.sv @@
module hcbd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            start_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input hcbd_pkg::kind_e                 kind_i,
  input logic [7:0]                      payload_byte_i,
  input logic [hcbd_pkg::BODY_LEN_W-1:0] body_length_i
);

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) &&
      $stable(payload_byte_i) && $stable(body_length_i))
    else $error("result changed while stalled");

  // Every accepted byte gives a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted byte gave no result");

  // Start of body is always a size line byte with a zero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && start_i |=>
      kind_i == hcbd_pkg::KIND_FRAME && body_length_i == '0)
    else $error("start of body not restarted");

  // Only payload results carry a byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i != hcbd_pkg::KIND_PAYLOAD |-> payload_byte_i == 8'd0)
    else $error("non-payload result carries a byte");

  // Empty output stage never blocks input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with empty output stage");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (body_i.valid),
  .in_ready_i     (body_i.ready),
  .start_i        (body_i.start_of_body),
  .out_valid_i    (res_o.valid),
  .out_ready_i    (res_o.ready),
  .kind_i         (res_o.kind),
  .payload_byte_i (res_o.payload_byte),
  .body_length_i  (res_o.body_length)
);
